// ----- design/rrsp_pkg.sv -----
// rrsp_pkg: shared types and constants for the reply stream parser.
// Holds the parse phase enum, element kinds, fault codes and stack sizing.
// No dependencies; imported by rrsp_stack and resp_reply_stream_parser_core.
`default_nettype none

package rrsp_pkg;

  // Array nesting limit and derived widths
  localparam int MAX_DEPTH = 8;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int COUNT_W   = 32;

  typedef enum logic [3:0] {
    PH_TYPE     = 4'd0,
    PH_LINE     = 4'd1,
    PH_LINE_LF  = 4'd2,
    PH_NUM_LEAD = 4'd3,
    PH_NUM_BODY = 4'd4,
    PH_NUM_LF   = 4'd5,
    PH_BULK     = 4'd6,
    PH_BULK_CR  = 4'd7,
    PH_BULK_LF  = 4'd8
  } phase_t;

  // Element kinds as reported on the result stream
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_STATUS = 3'd1;
  localparam logic [2:0] KIND_ERROR  = 3'd2;
  localparam logic [2:0] KIND_BULK   = 3'd3;
  localparam logic [2:0] KIND_ARRAY  = 3'd4;
  localparam logic [2:0] KIND_INT    = 3'd5;
  localparam logic [2:0] KIND_NULL   = 3'd6;

  // Fault codes
  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_TYPE  = 2'd1;
  localparam logic [1:0] FLT_CRLF  = 2'd2;
  localparam logic [1:0] FLT_RANGE = 2'd3;

  // Protocol characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_BULK  = 8'h24;
  localparam logic [7:0] CH_ARRAY = 8'h2A;
  localparam logic [7:0] CH_INT   = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Decimal saturation limits (magnitudes)
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LIM_DIV10 = 64'd922337203685477580;
  localparam logic [3:0]  POS_REM   = 4'd7;
  localparam logic [3:0]  NEG_REM   = 4'd8;
  localparam logic [63:0] U32_MAX   = 64'h0000_0000_FFFF_FFFF;

  // Request from the parser to the count stack for one accepted word
  typedef struct packed {
    logic               en;
    logic               clear;
    logic               push;
    logic               finish;
    logic [COUNT_W-1:0] value;
  } stk_req_t;

endpackage

`default_nettype wire

// ----- design/rrsp_stack.sv -----
// rrsp_stack: stack of remaining child counts for open arrays.
// Closes every exhausted level at once when an element finishes.
// Depends on rrsp_pkg.
`default_nettype none

module rrsp_stack (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rrsp_pkg::stk_req_t        req,
  output logic [rrsp_pkg::DEPTH_W-1:0]   sp_eff,
  output logic [rrsp_pkg::DEPTH_W-1:0]   sp_next
);
  import rrsp_pkg::*;

  logic [COUNT_W-1:0] counts [MAX_DEPTH];
  logic [DEPTH_W-1:0] sp;
  logic [DEPTH_W-1:0] sp_fin;
  logic [MAX_DEPTH:0] run;
  logic [MAX_DEPTH-1:0] ones;

  always_comb begin
    sp_eff = req.clear ? '0 : sp;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      ones[i] = (counts[i] == COUNT_W'(1));
    end
    // run[i]: every open level from i up to the top is down to its last child
    run[MAX_DEPTH] = 1'b1;
    for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
      run[i] = (DEPTH_W'(i) >= sp_eff) || (ones[i] && run[i+1]);
    end
    sp_fin = sp_eff;
    for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
      if ((DEPTH_W'(i) < sp_eff) && run[i]) begin
        sp_fin = DEPTH_W'(i);
      end
    end
    if (req.push) begin
      sp_next = sp_eff + DEPTH_W'(1);
    end else if (req.finish) begin
      sp_next = sp_fin;
    end else begin
      sp_next = sp_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (req.en) begin
      sp <= sp_next;
    end
  end

  // Write the pushed count, or count down the level left on top
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (req.en && req.push && (sp_eff == DEPTH_W'(i))) begin
        counts[i] <= req.value;
      end else if (req.en && req.finish && (sp_fin == DEPTH_W'(i + 1))) begin
        counts[i] <= counts[i] - COUNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/resp_reply_stream_parser_core.sv -----
// resp_reply_stream_parser_core: byte-wide parser for the RESP2 reply stream.
// The result word is registered: it is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the input stalls only while a result word waits.
// Reset: rst (synchronous, active high) clears parse state, stack pointer,
// fault and the output valid; a restart flag on a word clears all but the output valid first.
// Depends on rrsp_pkg and rrsp_stack.
`default_nettype none

module resp_reply_stream_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] restart
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] payload_byte, [8] element_done, [72:9] number_value, [73] in_reply,
  // [77:74] nest_depth, [78] fault, [80:79] fault_kind, [87:81] zero
  output logic [87:0]      m_tdata,
  output logic [3:0]       m_tuser,   // [0] payload_valid, [3:1] element_kind
  output logic             m_tlast    // reply_done
);
  import rrsp_pkg::*;

  // Parse state
  phase_t       phase;
  logic [2:0]   elem_type;
  logic [63:0]  accum;
  logic         negative;
  logic         digits_ended;
  logic [31:0]  bulk_left;
  logic         fault_flag;
  logic [1:0]   fault_code;

  phase_t       phase_next;
  logic [2:0]   elem_type_next;
  logic [63:0]  accum_next;
  logic         negative_next;
  logic         digits_ended_next;
  logic [31:0]  bulk_left_next;
  logic         fault_flag_next;
  logic [1:0]   fault_code_next;

  // Result register
  logic [7:0]   res_byte;
  logic         res_payload;
  logic         res_done;
  logic [2:0]   res_kind;
  logic [63:0]  res_value;
  logic         res_reply_done;
  logic         res_in_reply;
  logic [3:0]   res_depth;
  logic         res_fault;
  logic [1:0]   res_fault_kind;

  logic         accept;
  logic [7:0]   c;
  logic         restart;

  stk_req_t           stk_req;
  logic [DEPTH_W-1:0] sp_eff;
  logic [DEPTH_W-1:0] sp_next;

  // Per-word decisions
  logic         payload;
  logic         done;
  logic [2:0]   kind;
  logic         value_from_accum;
  logic         push;
  logic         finish;
  logic         raise;
  logic [1:0]   raise_code;
  logic         is_digit;
  logic [3:0]   digit;
  logic [63:0]  digit_accum;
  logic [63:0]  signed_val;
  logic         value_neg;

  phase_t       ph_eff;
  logic [2:0]   type_eff;
  logic [63:0]  acc_eff;
  logic         neg_eff;
  logic         ended_eff;
  logic [31:0]  bulk_eff;
  logic         fault_eff;
  logic [1:0]   code_eff;

  // Output register frees up when empty or when its word is taken
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign c        = s_tdata;
  assign restart  = s_tuser;

  rrsp_stack u_stack (
    .clk     (clk),
    .rst     (rst),
    .req     (stk_req),
    .sp_eff  (sp_eff),
    .sp_next (sp_next)
  );

  always_comb begin
    stk_req.en     = accept;
    stk_req.clear  = restart;
    stk_req.push   = push;
    stk_req.finish = finish;
    stk_req.value  = acc_eff[31:0];
  end

  // Restart acts as a reset applied ahead of this byte
  always_comb begin
    ph_eff    = restart ? PH_TYPE : phase;
    type_eff  = restart ? KIND_NONE : elem_type;
    acc_eff   = restart ? '0 : accum;
    neg_eff   = restart ? 1'b0 : negative;
    ended_eff = restart ? 1'b0 : digits_ended;
    bulk_eff  = restart ? '0 : bulk_left;
    fault_eff = restart ? 1'b0 : fault_flag;
    code_eff  = restart ? FLT_NONE : fault_code;
  end

  // Decimal digit accumulate with strtoll-style saturation
  always_comb begin
    logic [63:0] thresh;
    logic [63:0] lim;
    logic [3:0]  rem;
    is_digit = c inside {[CH_ZERO:CH_NINE]};
    digit    = c[3:0];
    lim      = neg_eff ? NEG_LIMIT : POS_LIMIT;
    rem      = neg_eff ? NEG_REM : POS_REM;
    thresh   = LIM_DIV10 - ((digit > rem) ? 64'd1 : 64'd0);
    if (acc_eff > thresh) begin
      digit_accum = lim;
    end else begin
      digit_accum = (acc_eff << 3) + (acc_eff << 1) + {60'd0, digit};
    end
    signed_val = neg_eff ? (64'd0 - acc_eff) : acc_eff;
    value_neg  = neg_eff && (acc_eff != 64'd0);
  end

  // Next phase; hold it on a fault, which sticks until restart or rst
  always_comb begin
    phase_next = ph_eff;
    if (!fault_eff) begin
      case (ph_eff)
        PH_TYPE: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            phase_next = PH_LINE;
          end else if (c inside {CH_BULK, CH_ARRAY, CH_INT}) begin
            phase_next = PH_NUM_LEAD;
          end
        end
        PH_LINE: begin
          if (c == CH_CR) begin
            phase_next = PH_LINE_LF;
          end
        end
        PH_LINE_LF: begin
          if (c == CH_LF) begin
            phase_next = PH_TYPE;
          end
        end
        PH_NUM_LEAD: begin
          if (c == CH_CR) begin
            phase_next = PH_NUM_LF;
          end else if (!(c inside {CH_SPACE, [CH_TAB:CH_FF]})) begin
            phase_next = PH_NUM_BODY;
          end
        end
        PH_NUM_BODY: begin
          if (c == CH_CR) begin
            phase_next = PH_NUM_LF;
          end
        end
        PH_NUM_LF: begin
          if (c == CH_LF && !raise) begin
            // a bulk header that is not null moves on to its payload, or to its CR when empty
            if (type_eff == KIND_BULK && !finish) begin
              phase_next = (acc_eff[31:0] != 32'd0) ? PH_BULK : PH_BULK_CR;
            end else begin
              phase_next = PH_TYPE;
            end
          end
        end
        PH_BULK: begin
          if (bulk_eff == 32'd1) begin
            phase_next = PH_BULK_CR;
          end
        end
        PH_BULK_CR: begin
          if (c == CH_CR) begin
            phase_next = PH_BULK_LF;
          end
        end
        PH_BULK_LF: begin
          if (c == CH_LF) begin
            phase_next = PH_TYPE;
          end
        end
        default: begin
          phase_next = PH_TYPE;
        end
      endcase
    end
  end

  // Per-word decisions and datapath next values
  always_comb begin
    elem_type_next    = type_eff;
    accum_next        = acc_eff;
    negative_next     = neg_eff;
    digits_ended_next = ended_eff;
    bulk_left_next    = bulk_eff;
    payload           = 1'b0;
    done              = 1'b0;
    kind              = KIND_NONE;
    value_from_accum  = 1'b0;
    push              = 1'b0;
    finish            = 1'b0;
    raise             = 1'b0;
    raise_code        = FLT_NONE;

    if (!fault_eff) begin
      case (ph_eff)
        PH_TYPE: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            elem_type_next = (c == CH_PLUS) ? KIND_STATUS : KIND_ERROR;
          end else if (c == CH_BULK || c == CH_ARRAY || c == CH_INT) begin
            elem_type_next    = (c == CH_BULK)  ? KIND_BULK :
                                (c == CH_ARRAY) ? KIND_ARRAY : KIND_INT;
            accum_next        = '0;
            negative_next     = 1'b0;
            digits_ended_next = 1'b0;
          end else begin
            raise      = 1'b1;
            raise_code = FLT_TYPE;
          end
        end
        PH_LINE: begin
          if (c != CH_CR) begin
            payload = 1'b1;
          end
        end
        PH_LINE_LF: begin
          if (c == CH_LF) begin
            finish = 1'b1;
            kind   = type_eff;
          end else begin
            raise      = 1'b1;
            raise_code = FLT_CRLF;
          end
        end
        PH_NUM_LEAD: begin
          if (c == CH_CR) begin
            // empty number line
          end else if (c inside {CH_SPACE, [CH_TAB:CH_FF]}) begin
            // skip leading blank
          end else begin
            if (c == CH_MINUS) begin
              negative_next = 1'b1;
            end else if (is_digit) begin
              accum_next = digit_accum;
            end else if (c != CH_PLUS) begin
              digits_ended_next = 1'b1;
            end
          end
        end
        PH_NUM_BODY: begin
          if (c == CH_CR) begin
            // line ends, wait for LF
          end else if (!ended_eff && is_digit) begin
            accum_next = digit_accum;
          end else begin
            digits_ended_next = 1'b1;
          end
        end
        PH_NUM_LF: begin
          if (c != CH_LF) begin
            raise      = 1'b1;
            raise_code = FLT_CRLF;
          end else if (type_eff == KIND_INT) begin
            finish           = 1'b1;
            kind             = KIND_INT;
            value_from_accum = 1'b1;
          end else if (value_neg) begin
            finish           = 1'b1;
            kind             = KIND_NULL;
            value_from_accum = 1'b1;
          end else if (type_eff == KIND_BULK) begin
            if (acc_eff > U32_MAX) begin
              raise      = 1'b1;
              raise_code = FLT_RANGE;
            end else begin
              bulk_left_next = acc_eff[31:0];
            end
          end else if (acc_eff == 64'd0) begin
            // empty array ends right here
            finish           = 1'b1;
            kind             = KIND_ARRAY;
            value_from_accum = 1'b1;
          end else if (acc_eff > U32_MAX || sp_eff >= DEPTH_W'(MAX_DEPTH)) begin
            raise      = 1'b1;
            raise_code = FLT_RANGE;
          end else begin
            // open the array: report it now, children follow
            push             = 1'b1;
            done             = 1'b1;
            kind             = KIND_ARRAY;
            value_from_accum = 1'b1;
          end
        end
        PH_BULK: begin
          payload        = 1'b1;
          bulk_left_next = bulk_eff - 32'd1;
        end
        PH_BULK_CR: begin
          if (c != CH_CR) begin
            raise      = 1'b1;
            raise_code = FLT_CRLF;
          end
        end
        PH_BULK_LF: begin
          if (c == CH_LF) begin
            finish           = 1'b1;
            kind             = KIND_BULK;
            value_from_accum = 1'b1;
          end else begin
            raise      = 1'b1;
            raise_code = FLT_CRLF;
          end
        end
        default: begin
          payload = 1'b0;
        end
      endcase
      if (finish) begin
        done = 1'b1;
      end
    end

    fault_flag_next = fault_eff || raise;
    fault_code_next = raise ? raise_code : code_eff;
  end

  // Parse state registers: advance on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      elem_type    <= KIND_NONE;
      accum        <= '0;
      negative     <= 1'b0;
      digits_ended <= 1'b0;
      bulk_left    <= '0;
      fault_flag   <= 1'b0;
      fault_code   <= FLT_NONE;
    end else if (accept) begin
      phase        <= phase_next;
      elem_type    <= elem_type_next;
      accum        <= accum_next;
      negative     <= negative_next;
      digits_ended <= digits_ended_next;
      bulk_left    <= bulk_left_next;
      fault_flag   <= fault_flag_next;
      fault_code   <= fault_code_next;
    end
  end

  // Output valid: set on accept, drop once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload; under fault only byte, depth and fault fields survive
  always_ff @(posedge clk) begin
    if (accept) begin
      res_byte  <= c;
      res_depth <= 4'(sp_next);
      if (fault_flag_next) begin
        res_payload    <= 1'b0;
        res_done       <= 1'b0;
        res_kind       <= KIND_NONE;
        res_value      <= '0;
        res_reply_done <= 1'b0;
        res_in_reply   <= 1'b0;
        res_fault      <= 1'b1;
        res_fault_kind <= fault_code_next;
      end else begin
        res_payload    <= payload;
        res_done       <= done;
        res_kind       <= kind;
        res_value      <= value_from_accum ? signed_val : 64'd0;
        res_reply_done <= finish && (sp_next == '0);
        res_in_reply   <= (phase_next != PH_TYPE) || (sp_next != '0);
        res_fault      <= 1'b0;
        res_fault_kind <= FLT_NONE;
      end
    end
  end

  assign m_tdata = {7'd0, res_fault_kind, res_fault, res_depth, res_in_reply,
                    res_value, res_done, res_byte};
  assign m_tuser = {res_kind, res_payload};
  assign m_tlast = res_reply_done;

endmodule

`default_nettype wire
